// File: src/spr_row_pkg.sv
// Shared types and constants for the two-plane OR-color sprite row encoder.
// No dependencies.
package spr_row_pkg;

	localparam int NUM_PIXELS  = 16;
	localparam int ROW_PIXELS  = 16;
	localparam int HALF_PIXELS = 8;
	localparam int MAX_COLORS  = 3;
	localparam int COLOR_W     = 4;
	localparam int COLOR_B_W   = 7;
	localparam logic [COLOR_B_W-1:0] OR_BIT = 7'd64;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [NUM_PIXELS-1:0][COLOR_W-1:0] pix_row_t;
	typedef logic [HALF_PIXELS-1:0] pattern_t;
	typedef color_t [MAX_COLORS-1:0] color_set_t;

	typedef logic reg_idx_t;
	localparam reg_idx_t REG_WIDE_SPRITE = 1'b0;
	localparam reg_idx_t REG_DUMMY_RIGHT = 1'b1;

endpackage

// File: src/spr_row_in_if.sv
// Input channel carrying one sprite row of palette indices.
// Depends on spr_row_pkg.
interface spr_row_in_if
	import spr_row_pkg::*;
();
	logic     valid;
	logic     ready;
	pix_row_t row_pixels;
	logic     last_row;

	modport source (output valid, output row_pixels, output last_row, input ready);
	modport sink   (input valid, input row_pixels, input last_row, output ready);
endinterface

// File: src/spr_row_out_if.sv
// Output channel carrying the two pattern planes, color bytes and flags of a row.
// Depends on spr_row_pkg.
interface spr_row_out_if
	import spr_row_pkg::*;
();
	logic                 valid;
	logic                 ready;
	pattern_t             plane_a_left;
	pattern_t             plane_a_right;
	pattern_t             plane_b_left;
	pattern_t             plane_b_right;
	color_t               color_a;
	logic [COLOR_B_W-1:0] color_b;
	logic                 too_many_colors;
	logic                 third_not_or;
	logic                 row_end;

	modport source (
		output valid, output plane_a_left, output plane_a_right, output plane_b_left,
		output plane_b_right, output color_a, output color_b, output too_many_colors,
		output third_not_or, output row_end, input ready
	);
	modport sink (
		input valid, input plane_a_left, input plane_a_right, input plane_b_left,
		input plane_b_right, input color_a, input color_b, input too_many_colors,
		input third_not_or, input row_end, output ready
	);
endinterface

// File: src/two_plane_or_color_sprite_row.sv
// Throughput: one row per cycle unless output backpressure stalls.
// Stages: mask + first-occurrence detect, color collect, 3-color sort, pattern build.
// Backpressure holds full stages in place, bubbles still fill; nothing is dropped.
// Reset clears all stage valid bits, sets wide_sprite to 1 and dummy_right to 0.
// Depends on spr_row_pkg, spr_row_in_if and spr_row_out_if.
module two_plane_or_color_sprite_row
	import spr_row_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  reg_idx_t      cfg_index,
	input  logic          cfg_wdata,
	spr_row_in_if.sink    row,
	spr_row_out_if.source result
);

	function automatic logic pix_on(color_t p, color_t main_col, color_t third_col);
		return (p != '0) && (main_col != '0) && ((p == main_col) || (p == third_col));
	endfunction

	logic wide_q, dummy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q  <= 1'b1;
			dummy_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDE_SPRITE: wide_q  <= cfg_wdata;
				REG_DUMMY_RIGHT: dummy_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || result.ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign row.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= row.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: drop pixels outside the row, flag first occurrence of each color
	pix_row_t                pix_m;
	logic [NUM_PIXELS-1:0]   first_m;
	pix_row_t                pix_s1;
	logic [NUM_PIXELS-1:0]   first_s1;
	logic                    last_s1;

	always_comb begin
		for (int j = 0; j < NUM_PIXELS; j++) begin
			if ((j < ROW_PIXELS) && (wide_q || (j < HALF_PIXELS)))
				pix_m[j] = row.row_pixels[j];
			else
				pix_m[j] = '0;
		end
		for (int j = 0; j < NUM_PIXELS; j++) begin
			first_m[j] = (pix_m[j] != '0);
			for (int i = 0; i < j; i++) begin
				if (pix_m[i] == pix_m[j])
					first_m[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1   <= pix_m;
			first_s1 <= first_m;
			last_s1  <= row.last_row;
		end
	end

	// stage 2: slot of each new color is the number of new colors before it
	color_set_t col_c;
	logic       many_c;
	pix_row_t   pix_s2;
	color_set_t col_s2;
	logic       many_s2, last_s2;

	always_comb begin
		col_c  = '0;
		many_c = ($countones(first_s1) > MAX_COLORS);
		for (int j = 0; j < NUM_PIXELS; j++) begin
			for (int r = 0; r < MAX_COLORS; r++) begin
				if (first_s1[j] &&
				    ($countones(first_s1 & ((NUM_PIXELS'(1) << j) - NUM_PIXELS'(1))) == r))
					col_c[r] = col_c[r] | pix_s1[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pix_s2  <= pix_s1;
			col_s2  <= col_c;
			many_s2 <= many_c;
			last_s2 <= last_s1;
		end
	end

	// stage 3: sort ascending; empty slots sort last by keying 0 above 15
	logic [COLOR_W:0] k0, k1, k2, ka, kb, kc, kd;
	color_set_t       col_sorted;
	logic             bad_c;
	pix_row_t         pix_s3;
	color_set_t       col_s3;
	logic             many_s3, bad_s3, last_s3;

	always_comb begin
		k0 = {col_s2[0] == '0, col_s2[0]};
		k1 = {col_s2[1] == '0, col_s2[1]};
		k2 = {col_s2[2] == '0, col_s2[2]};
		// compare-exchange (0,1), (1,2), (0,1)
		ka = (k0 > k1) ? k1 : k0;
		kb = (k0 > k1) ? k0 : k1;
		kc = (kb > k2) ? k2 : kb;
		col_sorted[2] = (kb > k2) ? kb[COLOR_W-1:0] : k2[COLOR_W-1:0];
		kd = (ka > kc) ? kc : ka;
		col_sorted[1] = (ka > kc) ? ka[COLOR_W-1:0] : kc[COLOR_W-1:0];
		col_sorted[0] = kd[COLOR_W-1:0];
		bad_c = (col_sorted[2] != '0) && ((col_sorted[0] | col_sorted[1]) != col_sorted[2]);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			pix_s3  <= pix_s2;
			col_s3  <= col_sorted;
			many_s3 <= many_s2;
			bad_s3  <= bad_c;
			last_s3 <= last_s2;
		end
	end

	// stage 4: pattern planes, pixel 0 (or 8) at the MSB
	pattern_t al_c, ar_c, bl_c, br_c;
	pattern_t al_s4, ar_s4, bl_s4, br_s4;
	color_t   ca_s4;
	logic [COLOR_B_W-1:0] cb_s4;
	logic     many_s4, bad_s4, last_s4;

	always_comb begin
		for (int j = 0; j < HALF_PIXELS; j++) begin
			al_c[HALF_PIXELS-1-j] = pix_on(pix_s3[j], col_s3[0], col_s3[2]);
			bl_c[HALF_PIXELS-1-j] = pix_on(pix_s3[j], col_s3[1], col_s3[2]);
			ar_c[HALF_PIXELS-1-j] = pix_on(pix_s3[HALF_PIXELS+j], col_s3[0], col_s3[2]);
			br_c[HALF_PIXELS-1-j] = pix_on(pix_s3[HALF_PIXELS+j], col_s3[1], col_s3[2]);
		end
		if (!wide_q) begin
			ar_c = '0;
			br_c = '0;
		end else if (dummy_q) begin
			ar_c[0] = 1'b0;
			br_c[0] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			al_s4   <= al_c;
			ar_s4   <= ar_c;
			bl_s4   <= bl_c;
			br_s4   <= br_c;
			ca_s4   <= col_s3[0];
			cb_s4   <= OR_BIT | {{(COLOR_B_W-COLOR_W){1'b0}}, col_s3[1]};
			many_s4 <= many_s3;
			bad_s4  <= bad_s3;
			last_s4 <= last_s3;
		end
	end

	assign result.valid           = valid_s4;
	assign result.plane_a_left    = al_s4;
	assign result.plane_a_right   = ar_s4;
	assign result.plane_b_left    = bl_s4;
	assign result.plane_b_right   = br_s4;
	assign result.color_a         = ca_s4;
	assign result.color_b         = cb_s4;
	assign result.too_many_colors = many_s4;
	assign result.third_not_or    = bad_s4;
	assign result.row_end         = last_s4;

endmodule
